// ----- rtl/sm3h_pkg.sv -----
package sm3h_pkg;

    // Input operation codes.
    localparam logic [1:0] OP_KEY  = 2'd0;
    localparam logic [1:0] OP_MSG  = 2'd1;
    localparam logic [1:0] OP_FIN  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [7:0]  IPAD_BYTE     = 8'h36;
    localparam logic [7:0]  OPAD_BYTE     = 8'h5C;
    localparam logic [7:0]  PAD_MARK_BYTE = 8'h80;
    localparam int          KEY_MAX_DEF   = 64;
    localparam int          BLOCK_BYTES   = 64;
    localparam logic [63:0] INNER_START_BITS = 64'd520;
    localparam logic [63:0] OUTER_BITS       = 64'd768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IKEY_LD,
        ST_IKEY_RUN,
        ST_MSG_LD,
        ST_MSG_RUN,
        ST_PAD_LD,
        ST_PAD_RUN,
        ST_LEN_LD,
        ST_LEN_RUN,
        ST_DIG_WR,
        ST_OKEY_LD,
        ST_OKEY_RUN,
        ST_OPAD_LD,
        ST_OPAD_RUN,
        ST_EMIT
    } state_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [5:0] back;
        back = 6'd32 - {1'b0, n};
        return (x << n) | (x >> back);
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

    function automatic logic [31:0] sm3_iv(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0: v = 32'h7380166F;
            3'd1: v = 32'h4914B2B9;
            3'd2: v = 32'h172442D7;
            3'd3: v = 32'hDA8A0600;
            3'd4: v = 32'hA96F30BC;
            3'd5: v = 32'h163138AA;
            3'd6: v = 32'hE38DEE4D;
            default: v = 32'hB0FB0E4E;
        endcase
        return v;
    endfunction

    // Round constant already rotated by the round number.
    function automatic logic [31:0] t_rot(input logic [5:0] j);
        logic [31:0] t;
        t = (j < 6'd16) ? 32'h79CC4519 : 32'h7A879D8A;
        return rotl32(t, j[4:0]);
    endfunction

endpackage

// ----- rtl/sm3h_core.sv -----
module sm3h_core
    import sm3h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        init,
    input  logic        shift_en,
    input  logic [7:0]  shift_byte,
    input  logic        start,
    output logic        busy,
    output logic        done,
    output logic [31:0] chain [8]
);

    logic [31:0] chain_reg [8];
    logic [31:0] win_reg [16];
    logic [31:0] st_reg [8];
    logic [31:0] st_next [8];
    logic [5:0]  j_reg;
    logic        run_reg;

    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, w_new;

    always_comb
    begin
        a12 = rotl32(st_reg[0], 5'd12);
        ss1 = rotl32(a12 + st_reg[4] + t_rot(j_reg), 5'd7);
        ss2 = ss1 ^ a12;
        if (j_reg < 6'd16)
        begin
            ff = st_reg[0] ^ st_reg[1] ^ st_reg[2];
            gg = st_reg[4] ^ st_reg[5] ^ st_reg[6];
        end
        else
        begin
            ff = (st_reg[0] & st_reg[1]) | (st_reg[0] & st_reg[2]) | (st_reg[1] & st_reg[2]);
            gg = (st_reg[4] & st_reg[5]) | (~st_reg[4] & st_reg[6]);
        end
        tt1 = ff + st_reg[3] + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2 = gg + st_reg[7] + ss1 + win_reg[0];
        st_next[0] = tt1;
        st_next[1] = st_reg[0];
        st_next[2] = rotl32(st_reg[1], 5'd9);
        st_next[3] = st_reg[2];
        st_next[4] = p0(tt2);
        st_next[5] = st_reg[4];
        st_next[6] = rotl32(st_reg[5], 5'd19);
        st_next[7] = st_reg[6];
        w_new = p1(win_reg[0] ^ win_reg[7] ^ rotl32(win_reg[13], 5'd15))
              ^ rotl32(win_reg[3], 5'd7) ^ win_reg[10];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            j_reg   <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            j_reg   <= '0;
        end
        else if (run_reg)
        begin
            j_reg <= j_reg + 6'd1;
            if (j_reg == 6'd63)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sm3_iv(3'(i));
            end
        end
        else if (run_reg && (j_reg == 6'd63))
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_reg[i] ^ st_next[i];
            end
        end

        if (start)
        begin
            st_reg <= chain_reg;
        end
        else if (run_reg)
        begin
            st_reg <= st_next;
        end

        // The window holds the 512-bit block as it streams in byte by
        // byte, then slides one expanded word per round.
        if (shift_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= {win_reg[i][23:0], win_reg[i+1][31:24]};
            end
            win_reg[15] <= {win_reg[15][23:0], shift_byte};
        end
        else if (run_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_new;
        end
    end

    assign busy  = run_reg;
    assign done  = run_reg && (j_reg == 6'd63);
    assign chain = chain_reg;

endmodule

// ----- rtl/sm3_hmac_engine_top.sv -----
// Channel  | Handshake                   | Payload
// item     | item_valid / item_stall     | op, data_byte
// result   | result_valid / result_stall | digest_word, word_index, status, last_word
//
// A key byte does not hold the item side. Nor does a message byte, except that the
// first one holds it for the keyed ipad block and every 64th for a compression
// (memory streaming including the read latency, then 64 SM3 rounds on the single
// round unit). A finish without error takes three or four compressions, a copy of
// the inner digest into the block memory, then the eight digest words; a finish
// with an error gives a single error word. Reset clears all control state; the
// memories need no clearing pass, since key bytes beyond the fill count read
// as zero.
// item_stall stays high from the cycle after an item that starts work until that
// work is done; for a finish, until its last result word has been taken.
module sm3_hmac_engine_top
    import sm3h_pkg::*;
#(
    parameter int KEY_MAX_BYTES = KEY_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        status,
    output logic        last_word
);

    localparam int KEY_AW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;

    state_t      state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [6:0]  key_count_reg, key_count_next;
    logic        key_ovf_reg, key_ovf_next;
    logic        started_reg, started_next;
    logic [63:0] bits_reg, bits_next;
    logic        err_reg, err_next;
    logic [2:0]  widx_reg, widx_next;
    logic        out_vld_reg, out_vld_next;
    logic [31:0] out_word_reg, out_word_next;
    logic        out_last_reg, out_last_next;

    // Key store and block buffer: one write and one registered read a cycle.
    logic [7:0]  key_mem [KEY_MAX_BYTES];
    logic [7:0]  blk_mem [BLOCK_BYTES];
    logic [7:0]  key_q_reg, blk_q_reg;
    logic        key_we, blk_we;
    logic [5:0]  blk_waddr;
    logic [7:0]  blk_wdata;

    logic        in_acc, out_acc, is_load, core_init, core_start, core_shift;
    logic        core_busy, core_done;
    logic [31:0] chain [8];
    logic [5:0]  ld_idx, pos;
    logic [7:0]  ld_byte, len_byte, key_byte, pad_byte;
    logic [31:0] dig_word;
    logic        fin_err;

    assign in_acc  = item_valid && !item_stall;
    assign out_acc = out_vld_reg && !result_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign pos = bits_reg[8:3];
    assign fin_err = (key_count_reg == 7'd0) || key_ovf_reg || !started_reg;

    assign is_load = (state_reg == ST_IKEY_LD) || (state_reg == ST_MSG_LD)
                  || (state_reg == ST_PAD_LD) || (state_reg == ST_LEN_LD)
                  || (state_reg == ST_OKEY_LD) || (state_reg == ST_OPAD_LD);

    // Read data is registered, so the byte in hand is cnt - 1.
    assign ld_idx   = 6'(cnt_reg - 7'd1);
    assign len_byte = bits_reg[{~ld_idx[2:0], 3'b000} +: 8];
    assign key_byte = (({1'b0, ld_idx} < key_count_reg) ? key_q_reg : 8'h00)
                    ^ ((state_reg == ST_OKEY_LD) ? OPAD_BYTE : IPAD_BYTE);

    always_comb
    begin
        if (ld_idx < pos)
        begin
            pad_byte = blk_q_reg;
        end
        else if (ld_idx == pos)
        begin
            pad_byte = PAD_MARK_BYTE;
        end
        else if ((pos < 6'd56) && (ld_idx >= 6'd56))
        begin
            pad_byte = len_byte;
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IKEY_LD, ST_OKEY_LD: ld_byte = key_byte;
            ST_PAD_LD, ST_OPAD_LD:  ld_byte = pad_byte;
            ST_LEN_LD:              ld_byte = (ld_idx >= 6'd56) ? len_byte : 8'h00;
            default:                ld_byte = blk_q_reg;
        endcase
    end

    assign core_shift = is_load && (cnt_reg != 7'd0);
    assign core_start = is_load && (cnt_reg == 7'd64);
    assign dig_word   = chain[cnt_reg[4:2]];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (op)
                        OP_MSG:
                        begin
                            if (!started_reg)
                            begin
                                state_next = ST_IKEY_LD;
                            end
                            else if (pos == 6'd63)
                            begin
                                state_next = ST_MSG_LD;
                            end
                        end
                        OP_FIN:  state_next = fin_err ? ST_EMIT : ST_PAD_LD;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_IKEY_LD:  if (core_start) state_next = ST_IKEY_RUN;
            ST_IKEY_RUN: if (core_done) state_next = ST_IDLE;
            ST_MSG_LD:   if (core_start) state_next = ST_MSG_RUN;
            ST_MSG_RUN:  if (core_done) state_next = ST_IDLE;
            ST_PAD_LD:   if (core_start) state_next = ST_PAD_RUN;
            ST_PAD_RUN:
            begin
                if (core_done)
                begin
                    state_next = (pos >= 6'd56) ? ST_LEN_LD : ST_DIG_WR;
                end
            end
            ST_LEN_LD:   if (core_start) state_next = ST_LEN_RUN;
            ST_LEN_RUN:  if (core_done) state_next = ST_DIG_WR;
            ST_DIG_WR:   if (cnt_reg == 7'd31) state_next = ST_OKEY_LD;
            ST_OKEY_LD:  if (core_start) state_next = ST_OKEY_RUN;
            ST_OKEY_RUN: if (core_done) state_next = ST_OPAD_LD;
            ST_OPAD_LD:  if (core_start) state_next = ST_OPAD_RUN;
            ST_OPAD_RUN: if (core_done) state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_acc && out_last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath controls and register updates.
    always_comb
    begin
        key_count_next = key_count_reg;
        key_ovf_next   = key_ovf_reg;
        started_next   = started_reg;
        bits_next      = bits_reg;
        err_next       = err_reg;
        widx_next      = widx_reg;
        out_vld_next   = out_vld_reg;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;
        key_we         = 1'b0;
        blk_we         = 1'b0;
        blk_waddr      = pos;
        blk_wdata      = data_byte;
        core_init      = 1'b0;
        cnt_next       = ((is_load || (state_reg == ST_DIG_WR)) && (state_next == state_reg))
                       ? cnt_reg + 7'd1 : 7'd0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (op == OP_KEY) && !started_reg)
                begin
                    if (key_count_reg < 7'(KEY_MAX_BYTES))
                    begin
                        key_we         = 1'b1;
                        key_count_next = key_count_reg + 7'd1;
                    end
                    else
                    begin
                        key_ovf_next = 1'b1;
                    end
                end
                else if (in_acc && (op == OP_MSG))
                begin
                    blk_we = 1'b1;
                    if (!started_reg)
                    begin
                        blk_waddr    = 6'd0;
                        bits_next    = INNER_START_BITS;
                        started_next = 1'b1;
                        core_init    = 1'b1;
                    end
                    else
                    begin
                        bits_next = bits_reg + 64'd8;
                    end
                end
                else if (in_acc && (op == OP_FIN))
                begin
                    err_next  = fin_err;
                    widx_next = 3'd0;
                end
            end
            ST_DIG_WR:
            begin
                blk_we    = 1'b1;
                blk_waddr = {1'b0, cnt_reg[4:0]};
                blk_wdata = dig_word[{~cnt_reg[1:0], 3'b000} +: 8];
                if (cnt_reg == 7'd31)
                begin
                    core_init = 1'b1;
                    bits_next = OUTER_BITS;
                end
            end
            ST_EMIT:
            begin
                if (!out_vld_reg)
                begin
                    out_vld_next  = 1'b1;
                    out_word_next = err_reg ? 32'd0 : chain[widx_reg];
                    out_last_next = err_reg || (widx_reg == 3'd7);
                end
                else if (out_acc)
                begin
                    out_vld_next = 1'b0;
                    widx_next    = widx_reg + 3'd1;
                    if (out_last_reg)
                    begin
                        key_count_next = 7'd0;
                        key_ovf_next   = 1'b0;
                        started_next   = 1'b0;
                        bits_next      = 64'd0;
                        err_next       = 1'b0;
                        widx_next      = 3'd0;
                        core_init      = 1'b1;
                    end
                end
            end
            default:
            begin
                blk_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            key_count_reg <= '0;
            key_ovf_reg   <= 1'b0;
            started_reg   <= 1'b0;
            bits_reg      <= '0;
            err_reg       <= 1'b0;
            widx_reg      <= '0;
            out_vld_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            key_count_reg <= key_count_next;
            key_ovf_reg   <= key_ovf_next;
            started_reg   <= started_next;
            bits_reg      <= bits_next;
            err_reg       <= err_next;
            widx_reg      <= widx_next;
            out_vld_reg   <= out_vld_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_count_reg[KEY_AW-1:0]] <= data_byte;
        end
        key_q_reg <= key_mem[cnt_reg[KEY_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (blk_we)
        begin
            blk_mem[blk_waddr] <= blk_wdata;
        end
        blk_q_reg <= blk_mem[cnt_reg[5:0]];
    end

    sm3h_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .init       (core_init),
        .shift_en   (core_shift),
        .shift_byte (ld_byte),
        .start      (core_start),
        .busy       (core_busy),
        .done       (core_done),
        .chain      (chain)
    );

    assign result_valid = out_vld_reg;
    assign digest_word  = out_word_reg;
    assign word_index   = err_reg ? 3'd0 : widx_reg;
    assign status       = err_reg;
    assign last_word    = out_last_reg;

    // A word on the result side means the item side is held off.
    a_result_blocks_items: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("result word shown while items are accepted");

    // The round unit only runs while the block is busy.
    a_core_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        core_busy |-> item_stall)
        else $error("round unit running while idle");

    // An error result is a single word.
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status) |-> (last_word && (word_index == 3'd0)))
        else $error("error result not a single final word");

    // The key fill count never passes the store depth.
    a_key_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= 7'(KEY_MAX_BYTES))
        else $error("key fill count beyond store depth");

endmodule

// ----- tb/sv/sm3_hmac_engine_checker.sv -----
module sm3_hmac_engine_checker
    import sm3h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        status,
    input  logic        last_word,
    output int          fail_count,
    output int          pending_words,
    output int          words_seen,
    output int          error_words_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        status;
        logic        last_word;
    } digest_out_t;

    localparam logic [31:0] SM3_IV [8] = '{32'h7380166F, 32'h4914B2B9, 32'h172442D7,
        32'hDA8A0600, 32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

    digest_out_t digest_q[$];

    logic [7:0]  key_bytes [64];
    int          key_len;
    bit          key_too_long;
    logic [31:0] inner_cv [8];
    logic [7:0]  msg_block [64];
    logic [63:0] stream_bits;
    bit          msg_seen;

    function automatic logic [31:0] rol(logic [31:0] x, int n);
        n = n % 32;
        if (n == 0)
            return x;
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic sm3_compress(ref logic [31:0] v [8], input logic [7:0] blk [64]);
        logic [31:0] w [68];
        logic [31:0] a, b, c, d, e, f, g, h, ss1, ss2, ff, gg, tt1, tt2, t, x;
        for (int j = 0; j < 16; j++)
            w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
        for (int j = 16; j < 68; j++)
        begin
            x = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
            w[j] = (x ^ rol(x, 15) ^ rol(x, 23)) ^ rol(w[j-13], 7) ^ w[j-6];
        end
        a = v[0]; b = v[1]; c = v[2]; d = v[3];
        e = v[4]; f = v[5]; g = v[6]; h = v[7];
        for (int j = 0; j < 64; j++)
        begin
            t = (j < 16) ? 32'h79CC4519 : 32'h7A879D8A;
            ss1 = rol(rol(a, 12) + e + rol(t, j), 7);
            ss2 = ss1 ^ rol(a, 12);
            ff = (j < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
            gg = (j < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
            tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + h + ss1 + w[j];
            d = c; c = rol(b, 9); b = a; a = tt1;
            h = g; g = rol(f, 19); f = e;
            e = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
        end
        v[0] ^= a; v[1] ^= b; v[2] ^= c; v[3] ^= d;
        v[4] ^= e; v[5] ^= f; v[6] ^= g; v[7] ^= h;
    endtask

    task automatic pad_key_block(ref logic [31:0] v [8], input logic [7:0] pad);
        logic [7:0] blk [64];
        v = SM3_IV;
        for (int i = 0; i < 64; i++)
            blk[i] = key_bytes[i] ^ pad;
        sm3_compress(v, blk);
    endtask

    task automatic close_hash(ref logic [31:0] v [8], ref logic [7:0] buffer [64],
                              input logic [63:0] bits);
        int pos;
        pos = int'(bits[8:3]);
        buffer[pos] = PAD_MARK_BYTE;
        for (int i = pos + 1; i < 64; i++)
            buffer[i] = 8'h00;
        if (pos >= 56)
        begin
            sm3_compress(v, buffer);
            for (int i = 0; i < 64; i++)
                buffer[i] = 8'h00;
        end
        for (int i = 0; i < 8; i++)
            buffer[56+i] = bits[63-8*i -: 8];
        sm3_compress(v, buffer);
    endtask

    task automatic clear_hmac_state();
        for (int i = 0; i < 64; i++)
        begin
            key_bytes[i] = 8'h00;
            msg_block[i] = 8'h00;
        end
        key_len = 0;
        key_too_long = 0;
        inner_cv = SM3_IV;
        stream_bits = '0;
        msg_seen = 0;
    endtask

    task automatic absorb_word(input logic [1:0] code, input logic [7:0] value);
        logic [31:0] outer_cv [8];
        logic [7:0]  tail [64];
        int          pos;
        digest_out_t r;
        case (code)
            OP_KEY:
                if (!msg_seen)
                begin
                    if (key_len < 64)
                    begin
                        key_bytes[key_len] = value;
                        key_len++;
                    end
                    else
                        key_too_long = 1;
                end
            OP_MSG:
            begin
                if (!msg_seen)
                begin
                    pad_key_block(inner_cv, IPAD_BYTE);
                    stream_bits = 64'd512;
                    msg_seen = 1;
                end
                pos = int'(stream_bits[8:3]);
                msg_block[pos] = value;
                stream_bits += 64'd8;
                if (pos == 63)
                    sm3_compress(inner_cv, msg_block);
            end
            OP_FIN:
            begin
                if (key_len == 0 || key_too_long || !msg_seen)
                begin
                    r = '{digest_word: '0, word_index: '0, status: 1'b1, last_word: 1'b1};
                    digest_q.push_back(r);
                end
                else
                begin
                    close_hash(inner_cv, msg_block, stream_bits);
                    pad_key_block(outer_cv, OPAD_BYTE);
                    for (int i = 0; i < 64; i++)
                        tail[i] = 8'h00;
                    for (int i = 0; i < 8; i++)
                        {tail[4*i], tail[4*i+1], tail[4*i+2], tail[4*i+3]} = inner_cv[i];
                    close_hash(outer_cv, tail, OUTER_BITS);
                    for (int i = 0; i < 8; i++)
                    begin
                        r = '{digest_word: outer_cv[i], word_index: 3'(i),
                              status: 1'b0, last_word: (i == 7)};
                        digest_q.push_back(r);
                    end
                end
                clear_hmac_state();
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        digest_out_t exp_r;
        int          errs;
        errs = 0;
        if (!rst_n)
        begin
            clear_hmac_state();
            digest_q.delete();
            fail_count <= 0;
            words_seen <= 0;
            error_words_seen <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                words_seen <= words_seen + 1;
                if (status)
                    error_words_seen <= error_words_seen + 1;
                if (digest_q.size() == 0)
                begin
                    $error("unexpected result word %h", digest_word);
                    errs++;
                end
                else
                begin
                    exp_r = digest_q.pop_front();
                    if (digest_word !== exp_r.digest_word)
                    begin
                        $error("digest_word expected %h actual %h",
                               exp_r.digest_word, digest_word);
                        errs++;
                    end
                    if (word_index !== exp_r.word_index)
                    begin
                        $error("word_index expected %0d actual %0d",
                               exp_r.word_index, word_index);
                        errs++;
                    end
                    if (status !== exp_r.status)
                    begin
                        $error("status expected %0d actual %0d", exp_r.status, status);
                        errs++;
                    end
                    if (last_word !== exp_r.last_word)
                    begin
                        $error("last_word expected %0d actual %0d",
                               exp_r.last_word, last_word);
                        errs++;
                    end
                end
            end
            if (item_valid && !item_stall)
                absorb_word(op, data_byte);
            fail_count <= fail_count + errs;
        end
        pending_words <= digest_q.size();
    end

endmodule

// ----- tb/sv/sm3_hmac_engine_top_tb.sv -----
module sm3_hmac_engine_top_tb;
    import sm3h_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  op;
    logic [7:0]  data_byte;
    logic        result_valid;
    logic        result_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        status;
    logic        last_word;
    int          fail_count;
    int          pending_words;
    int          words_seen;
    int          error_words_seen;

    // Idle rates in percent for the sender and the receiver.
    int send_idle_pct;
    int recv_idle_pct;
    int words_sent;
    int hmacs_sent;

    sm3_hmac_engine_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .op(op), .data_byte(data_byte),
        .result_valid(result_valid), .result_stall(result_stall),
        .digest_word(digest_word), .word_index(word_index),
        .status(status), .last_word(last_word)
    );

    // The checker watches both channels, runs its own HMAC-SM3 and compares.
    sm3_hmac_engine_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .op(op), .data_byte(data_byte),
        .result_valid(result_valid), .result_stall(result_stall),
        .digest_word(digest_word), .word_index(word_index),
        .status(status), .last_word(last_word),
        .fail_count(fail_count), .pending_words(pending_words),
        .words_seen(words_seen), .error_words_seen(error_words_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // The receiver stalls at random; the draw is made afresh at every edge.
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Presents one word and holds it until the block has taken it. The sender
    // may leave a gap beforehand, with valid low.
    task automatic send_word(input logic [1:0] code, input logic [7:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        op <= code;
        data_byte <= value;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
        if (code == OP_FIN)
            hmacs_sent++;
    endtask

    task automatic go_quiet();
        item_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One HMAC: a key and a message, with random bytes or a fixed fill byte, then finish.
    task automatic run_hmac(input int key_n, input int msg_n, input logic [7:0] fill,
                            input bit random_fill);
        for (int i = 0; i < key_n; i++)
            send_word(OP_KEY, random_fill ? 8'($urandom) : fill);
        for (int i = 0; i < msg_n; i++)
            send_word(OP_MSG, random_fill ? 8'($urandom) : fill);
        send_word(OP_FIN, 8'($urandom));
    endtask

    task automatic random_phase(input int n_items);
        int start;
        int pick;
        start = words_sent;
        while (words_sent - start < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                // Mostly well-formed, with short messages, so that the padding
                // that fits in the last block is reached.
                run_hmac($urandom_range(1, 8), $urandom_range(1, 12), 8'h00, 1);
            else if (pick < 82)
                // A message near a block boundary of the inner hash, at times crossing it.
                run_hmac($urandom_range(1, 64), $urandom_range(52, 70), 8'h00, 1);
            else if (pick < 88)
                // Sequences that may be broken: key or message at random missing.
                run_hmac($urandom_range(0, 1) * $urandom_range(1, 4),
                         ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4), 8'h00, 1);
            else if (pick < 94)
                // Key bytes after the message, and op 3, are both ignored.
                begin
                    send_word(OP_KEY, 8'($urandom));
                    send_word(OP_MSG, 8'($urandom));
                    send_word(OP_KEY, 8'($urandom));
                    send_word(OP_NONE, 8'($urandom));
                    send_word(OP_FIN, 8'($urandom));
                end
            else
                send_word(2'($urandom_range(0, 3)), 8'($urandom));
        end
        // Close whatever a noise word left open.
        send_word(OP_FIN, 8'h00);
    endtask

    task automatic drain();
        go_quiet();
        while (pending_words != 0)
            @(posedge clk);
        // A finish may still be busy; let its tail run out.
        repeat (600) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        op = OP_NONE;
        data_byte = 8'h00;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        words_sent = 0;
        hmacs_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: extremes of the key length, all-ones and all-zero
        // bytes, each error case and the ignored op code.
        run_hmac(1, 1, 8'hFF, 0);
        run_hmac(64, 1, 8'h00, 0);
        run_hmac(65, 1, 8'hAA, 0);
        run_hmac(0, 2, 8'h55, 0);
        run_hmac(2, 0, 8'h01, 0);
        // The sender holds off here until every word owed has come back.
        drain();
        send_word(OP_NONE, 8'hFF);
        send_word(OP_KEY, 8'h80);
        send_word(OP_MSG, 8'h7F);
        send_word(OP_KEY, 8'h12);
        send_word(OP_FIN, 8'hFF);

        send_idle_pct = 9;
        recv_idle_pct = 76;
        random_phase(30);
        send_idle_pct = 76;
        recv_idle_pct = 9;
        random_phase(30);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(30);
        drain();

        $display("Sent %0d words in %0d finishes; %0d result words back, %0d of them errors.",
                 words_sent, hmacs_sent, words_seen, error_words_seen);
        if (fail_count == 0 && pending_words == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sm3h_pkg.sv
rtl/sm3h_core.sv
rtl/sm3_hmac_engine_top.sv
tb/sv/sm3_hmac_engine_checker.sv
tb/sv/sm3_hmac_engine_top_tb.sv
